[rtl/core/afs_pkg.sv]
package afs_pkg;

    localparam int FRAME_IDX_W  = 8;
    localparam int FRAME_CNT_W  = 9;
    localparam int DELAY_W      = 16;
    localparam int TIME_W       = 32;
    localparam int STORE_DEPTH  = 256;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 9;

    localparam logic [CFG_IDX_W-1:0]   CFG_FRAME_COUNT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0]   CFG_DISPLAY_ACTIVE = 8'd1;
    localparam logic [FRAME_CNT_W-1:0] FRAME_COUNT_RESET  = 9'd1;

    localparam logic [DELAY_W-1:0] SHORT_DELAY_MS  = 16'd10;
    localparam logic [TIME_W-1:0]  BUMPED_DELAY_MS = 32'd100;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [FRAME_IDX_W-1:0] entry_index;
        logic [DELAY_W-1:0]     delay_value;
        logic [TIME_W-1:0]      now_ms;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   frame_changed;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EVAL,
        ST_WALK,
        ST_FINISH
    } afs_state_t;

    typedef struct packed {
        logic take;
        logic load;
        logic eval;
        logic walk;
        logic finish;
    } afs_cmd_t;

    typedef struct packed {
        logic in_mode;
        logic display_active;
        logic go;
        logic eval_walk;
        logic walk_more;
        logic out_free;
    } afs_status_t;

endpackage

[rtl/core/afs_ram.sv]
module afs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/afs_ctrl.sv]
module afs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  afs_pkg::afs_status_t status,
    output afs_pkg::afs_cmd_t    cmd
);

    afs_pkg::afs_state_t state_reg;
    afs_pkg::afs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= afs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            afs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (status.in_mode == afs_pkg::MODE_LOAD) begin
                        state_next = afs_pkg::ST_LOAD;
                    end else if (status.display_active) begin
                        state_next = afs_pkg::ST_EVAL;
                    end else begin
                        state_next = afs_pkg::ST_FINISH;
                    end
                end
            end
            afs_pkg::ST_LOAD: begin
                state_next = afs_pkg::ST_FINISH;
            end
            afs_pkg::ST_EVAL: begin
                if (status.go && status.eval_walk) begin
                    state_next = afs_pkg::ST_WALK;
                end else begin
                    state_next = afs_pkg::ST_FINISH;
                end
            end
            afs_pkg::ST_WALK: begin
                if (!status.walk_more) begin
                    state_next = afs_pkg::ST_FINISH;
                end
            end
            afs_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    state_next = afs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = afs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            afs_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            afs_pkg::ST_LOAD: begin
                cmd.load = 1'b1;
            end
            afs_pkg::ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            afs_pkg::ST_WALK: begin
                cmd.walk = 1'b1;
            end
            afs_pkg::ST_FINISH: begin
                cmd.finish = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    a_take_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> state_reg != afs_pkg::ST_IDLE)
        else $error("Accepted word did not start processing.");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("More than one datapath command at once.");

endmodule

[rtl/core/afs_datapath.sv]
module afs_datapath #(
    parameter int MAX_FRAMES = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  afs_pkg::in_item_t                   s_data,
    input  logic                                cfg_valid,
    input  logic [afs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output afs_pkg::out_item_t                  m_data,
    input  afs_pkg::afs_cmd_t                   cmd,
    output afs_pkg::afs_status_t                status
);

    localparam int CW = afs_pkg::FRAME_CNT_W;
    localparam int FW = afs_pkg::FRAME_IDX_W;
    localparam int FRAME_LIMIT =
        (MAX_FRAMES < afs_pkg::STORE_DEPTH) ? MAX_FRAMES : afs_pkg::STORE_DEPTH;
    localparam logic [CW-1:0] LIMIT_N = CW'(FRAME_LIMIT);
    localparam logic [CW-1:0] ONE_N   = CW'(1);

    afs_pkg::in_item_t  item_reg;
    afs_pkg::out_item_t m_data_reg;
    logic               m_valid_reg, m_valid_next;

    logic [CW-1:0]                  frame_count_reg;
    logic                           display_active_reg;
    logic [afs_pkg::DELAY_W-1:0]    first_delay_reg, first_delay_next;
    logic                           uniform_reg, uniform_next;
    logic [FW-1:0]                  cur_reg, cur_next;
    logic [afs_pkg::TIME_W-1:0]     last_change_reg, last_change_next;
    logic [CW-1:0]                  steps_reg, steps_next;
    logic                           changed_reg, changed_next;

    logic [afs_pkg::DELAY_W-1:0]    rd_data;
    logic [CW-1:0]                  used_n;
    logic [CW-1:0]                  cur_inc;
    logic [FW-1:0]                  cur_step;
    logic [afs_pkg::TIME_W:0]       elapsed;
    logic                           reach, hold_short, go, walk_more;

    afs_ram #(
        .WIDTH (afs_pkg::DELAY_W),
        .DEPTH (afs_pkg::STORE_DEPTH)
    ) u_delay_ram (
        .aclk    (aclk),
        .wr_en   (cmd.load),
        .wr_addr (item_reg.entry_index),
        .wr_data (item_reg.delay_value),
        .rd_addr (cur_next),
        .rd_data (rd_data)
    );

    always_comb begin
        if (frame_count_reg > LIMIT_N) begin
            used_n = LIMIT_N;
        end else if (frame_count_reg == '0) begin
            used_n = ONE_N;
        end else begin
            used_n = frame_count_reg;
        end
    end

    assign cur_inc  = {1'b0, cur_reg} + ONE_N;
    assign cur_step = (cur_inc >= used_n) ? '0 : cur_inc[FW-1:0];

    assign elapsed    = {1'b0, item_reg.now_ms} - {1'b0, last_change_reg};
    assign reach      = !elapsed[afs_pkg::TIME_W]
                        && (elapsed[afs_pkg::TIME_W-1:0] >= {16'b0, rd_data});
    assign hold_short = uniform_reg && (rd_data <= afs_pkg::SHORT_DELAY_MS)
                        && (elapsed[afs_pkg::TIME_W-1:0] < afs_pkg::BUMPED_DELAY_MS);
    assign go         = reach && !hold_short;
    assign walk_more  = !uniform_reg && (rd_data == '0) && (steps_reg < used_n);

    assign status.in_mode        = s_data.mode;
    assign status.display_active = display_active_reg;
    assign status.go             = go;
    assign status.eval_walk      = !uniform_reg && (ONE_N < used_n);
    assign status.walk_more      = walk_more;
    assign status.out_free       = !m_valid_reg || m_ready;

    always_comb begin
        first_delay_next = first_delay_reg;
        uniform_next     = uniform_reg;
        cur_next         = cur_reg;
        last_change_next = last_change_reg;
        steps_next       = steps_reg;
        changed_next     = changed_reg;
        if (cmd.take) begin
            changed_next = 1'b0;
        end
        unique if (cmd.load) begin
            if (item_reg.entry_index == '0) begin
                first_delay_next = item_reg.delay_value;
                uniform_next     = 1'b1;
                cur_next         = '0;
                last_change_next = item_reg.now_ms;
            end else if (item_reg.delay_value != first_delay_reg) begin
                uniform_next = 1'b0;
            end
        end else if (cmd.eval) begin
            if (go) begin
                cur_next         = cur_step;
                last_change_next = item_reg.now_ms;
                steps_next       = ONE_N;
                changed_next     = 1'b1;
            end
        end else if (cmd.walk) begin
            if (walk_more) begin
                cur_next   = cur_step;
                steps_next = steps_reg + ONE_N;
            end
        end else begin
            cur_next = cur_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg    <= afs_pkg::FRAME_COUNT_RESET;
            display_active_reg <= 1'b0;
            first_delay_reg    <= '0;
            uniform_reg        <= 1'b1;
            cur_reg            <= '0;
            last_change_reg    <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && (cfg_index == afs_pkg::CFG_FRAME_COUNT)) begin
                frame_count_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == afs_pkg::CFG_DISPLAY_ACTIVE)) begin
                display_active_reg <= cfg_data[0];
            end
            first_delay_reg <= first_delay_next;
            uniform_reg     <= uniform_next;
            cur_reg         <= cur_next;
            last_change_reg <= last_change_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
        end
        steps_reg   <= steps_next;
        changed_reg <= changed_next;
        if (cmd.finish) begin
            m_data_reg.frame_index   <= cur_reg;
            m_data_reg.frame_changed <= changed_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_walk_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> (steps_reg <= used_n) && !uniform_reg)
        else $error("Zero-delay skip ran past the frame count.");

    a_load_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && (item_reg.mode == afs_pkg::MODE_LOAD)) |-> !changed_reg)
        else $error("Load word reported a frame change.");

    a_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && (item_reg.entry_index == '0)) |=> (cur_reg == '0) && uniform_reg)
        else $error("Loading the first entry did not rewind the animation.");

endmodule

[rtl/core/animation_frame_sequencer.sv]
// Frame timer for an animated image. A load word (mode 0) stores one frame delay;
// loading entry 0 restarts the animation at frame 0 and stamps the time. While the
// display is enabled, a tick word (mode 1) carries the current time in ms and moves
// to the next frame once the current frame's delay has elapsed (equal delays of 10 ms
// or less wait 100 ms), skipping zero-delay frames when the delays are not all equal.
// Every word returns exactly one result word. The zero-delay skip examines at most as
// many frames as the frame count (itself held to MAX_FRAMES and to 256) and reads the
// delay memory once per cycle. A result word that has not been taken yet holds the
// block in its last cycle. Register 0 sets the frame count and register 1 enables the
// display; write them only while the block is idle.
module animation_frame_sequencer #(
    parameter int MAX_FRAMES = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  afs_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output afs_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [afs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    afs_pkg::afs_cmd_t    cmd;
    afs_pkg::afs_status_t status;

    assign cfg_ready = 1'b1;

    afs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    afs_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
